// ===== rtl/cnms_pkg.sv =====
// Shared constants, codes and the CORDIC angle table of the edge thinning block.
`timescale 1ns / 1ps

package cnms_pkg;

  localparam int unsigned GRAD_BITS         = 16;
  localparam int unsigned DEFAULT_MAX_WIDTH = 1024;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT       = 11'd1024;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 112;

  localparam int unsigned POS_W   = 19;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned ANGLE_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 21'h1FFFFF;
  localparam logic signed [23:0] POS_MAX   = 24'sd524287;

  localparam int unsigned CORDIC_W = 28;
  localparam int unsigned ZACC_W   = 24;

  localparam logic signed [ZACC_W-1:0] QUARTER_TURN = 24'sd2949120;
  localparam logic signed [ZACC_W-1:0] ANGLE_LIMIT  = 24'sd23040;

  // Arctangent of 2^-i in units of 2^-15 degree.
  function automatic logic signed [ZACC_W-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ZACC_W-1:0] val;
    unique case (idx)
      4'd0:    val = 24'sd1474560;
      4'd1:    val = 24'sd870484;
      4'd2:    val = 24'sd459940;
      4'd3:    val = 24'sd233473;
      4'd4:    val = 24'sd117189;
      4'd5:    val = 24'sd58652;
      4'd6:    val = 24'sd29333;
      4'd7:    val = 24'sd14667;
      4'd8:    val = 24'sd7334;
      4'd9:    val = 24'sd3667;
      4'd10:   val = 24'sd1833;
      4'd11:   val = 24'sd917;
      4'd12:   val = 24'sd458;
      4'd13:   val = 24'sd229;
      4'd14:   val = 24'sd115;
      default: val = 24'sd57;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/cnms_cordic.sv =====
// Iterative vectoring CORDIC that turns a gradient into the edge normal angle.
`timescale 1ns / 1ps

module cnms_cordic (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [cnms_pkg::GRAD_BITS-1:0]   gx_i,
  input  logic signed [cnms_pkg::GRAD_BITS-1:0]   gy_i,
  output logic                                    done_o,
  output logic signed [cnms_pkg::ANGLE_W-1:0]     angle_o
);
  import cnms_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_e;

  cstate_e                    state_q;
  logic [3:0]                 iter_q;
  logic signed [CORDIC_W-1:0] x_q, y_q;
  logic signed [ZACC_W-1:0]   z_q;
  logic signed [ANGLE_W-1:0]  angle_q;

  logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
  logic signed [ZACC_W-1:0]   zr;

  always_comb begin
    x0 = $signed({{(CORDIC_W-GRAD_BITS-8){gx_i[GRAD_BITS-1]}}, gx_i, 8'h00});
    y0 = -$signed({{(CORDIC_W-GRAD_BITS-8){gy_i[GRAD_BITS-1]}}, gy_i, 8'h00});
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    zr = (z_q + 24'sd128) >>> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      iter_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      angle_q <= '0;
    end else begin
      unique case (state_q)
        C_IDLE, C_DONE: begin
          if (start_i) begin
            iter_q <= '0;
            if (gx_i == '0 && gy_i == '0) begin
              angle_q <= '0;
              state_q <= C_DONE;
            end else if (gy_i == '0 && gx_i[GRAD_BITS-1]) begin
              angle_q <= -ANGLE_W'(ANGLE_LIMIT);
              state_q <= C_DONE;
            end else begin
              state_q <= C_RUN;
              if (x0 < 0) begin
                // Fold the left half plane onto the right by a quarter turn.
                if (y0 >= 0) begin
                  x_q <= y0;
                  y_q <= -x0;
                  z_q <= QUARTER_TURN;
                end else begin
                  x_q <= -y0;
                  y_q <= x0;
                  z_q <= -QUARTER_TURN;
                end
              end else begin
                x_q <= x0;
                y_q <= y0;
                z_q <= '0;
              end
            end
          end
        end
        C_RUN: begin
          if (y_q >= 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_lut(iter_q);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_lut(iter_q);
          end
          iter_q <= iter_q + 4'd1;
          if (iter_q == 4'd15) begin
            state_q <= C_DONE;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
      if (state_q == C_RUN && iter_q == 4'd15) begin
        angle_q <= '0;
      end
      // The last step result is rounded combinationally once the done state is entered.
    end
  end

  // Rounding and clamping of the accumulated angle; valid once the run is over.
  logic signed [ANGLE_W-1:0] run_angle;
  always_comb begin
    if (zr > ANGLE_LIMIT) begin
      run_angle = ANGLE_W'(ANGLE_LIMIT);
    end else if (zr < -ANGLE_LIMIT) begin
      run_angle = -ANGLE_W'(ANGLE_LIMIT);
    end else begin
      run_angle = ANGLE_W'(zr);
    end
  end

  // After a run the held angle register is zero and the accumulator result is
  // selected; for the special cases the accumulator is not touched.
  logic from_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_run_q <= 1'b0;
    end else if (state_q == C_RUN && iter_q == 4'd15) begin
      from_run_q <= 1'b1;
    end else if (start_i && state_q != C_RUN) begin
      from_run_q <= 1'b0;
    end
  end

  assign done_o  = (state_q == C_DONE);
  assign angle_o = from_run_q ? run_angle : angle_q;

endmodule

// ===== rtl/canny_nms_subpixel_top.sv =====
// Top level of the streaming Canny non-maximum suppression with subpixel edge output.
`timescale 1ns / 1ps

// Pixels arrive in raster order, one transaction each, carrying the horizontal
// and vertical gradient and the gradient magnitude. The block keeps one line
// memory of MAX_WIDTH words (two rows of magnitude plus the gradients of the
// row above) and a 3x3 magnitude window, so the pixel tested is the one a row
// up and a column left of the arriving one. Each interior pixel passes a
// dominant axis maximum test, an octant choice by exact integer compares and a
// diagonal maximum test; survivors get a parabolic subpixel offset from a
// restoring divider and a normal angle from a 16-step CORDIC that runs beside
// it. An edge produces one output transaction with column, row, subpixel
// position (8 fraction bits), strength, angle (Q8.7 degrees) and the running
// edge count of the frame, which restarts after the last pixel of a frame.
// Timing: the block takes one pixel at a time and accepts the next one only once
// it is through with the last, whether that pixel is no edge candidate, is
// rejected or is an edge. An edge passes the window, axis, square, octant and
// check steps and then the 16 CORDIC iterations; an edge whose gradient is zero
// or points straight left needs no CORDIC run.
// A full edge register that waits on m_axis_tready adds its stall cycles.
// The shared multiplier forms the three squares in turn, and the divider runs
// beside the CORDIC.
// After reset a clearing pass zeroes every word of the line memory while
// s_axis_tready stays low; configuration writes are taken at any time.
module canny_nms_subpixel_top #(
  parameter int unsigned MAX_WIDTH = cnms_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [cnms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cnms_pkg::CFG_W-1:0]       cfg_data_i,
  // Pixel stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: grad_x [15:0], grad_y [31:16], magnitude [47:32]
  input  logic [cnms_pkg::IN_W-1:0]        s_axis_tdata,
  // Edge stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: column [9:0], row [19:10], pos_x [38:20], pos_y [57:39],
  // strength [73:58], normal_angle [89:74], edge_count [110:90], zero [111]
  output logic [cnms_pkg::OUT_W-1:0]       m_axis_tdata
);
  import cnms_pkg::*;

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned MEM_W = 4 * GRAD_BITS;
  localparam int unsigned G     = GRAD_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_AXIS, S_MUL0, S_MUL1, S_MUL2,
    S_OCT, S_CHECK, S_DIV, S_WAIT, S_EMIT
  } state_e;

  // Interpolation axis: vertical, horizontal, left diagonal, right diagonal.
  typedef enum logic [1:0] {DIR_V, DIR_H, DIR_L, DIR_R} dir_e;

  state_e           state_q;
  logic [AW-1:0]    clr_q;
  logic [CFG_W-1:0] width_q, height_q;
  logic [AW-1:0]    col_q;
  logic [9:0]       row_q;
  logic [COUNT_W-1:0] edge_q;

  logic [G-1:0]     in_gx_q, in_gy_q, in_mag_q;
  logic [MEM_W-1:0] rd_q;
  logic [G-1:0]     win_q [9];
  logic [G-1:0]     cgx_q, cgy_q;
  logic signed [G-1:0] egx_q, egy_q;
  logic [G:0]       ax_q, ay_q;
  logic [AW-1:0]    x_q;
  logic [9:0]       y_q;
  logic             frame_end_q;
  logic [2*G+1:0]   ss_q, aa_q, dd_q;
  dir_e             dir_q;
  logic signed [G+1:0] num_q;
  logic signed [G+3:0] den_q;
  logic [G+9:0]     rem_q;
  logic [G+3:0]     dv_q;
  logic [7:0]       quo_q;
  logic             neg_q;
  logic [2:0]       step_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  // Line memory: {mag two rows up, mag one row up, gx, gy} of the row above.
  logic [MEM_W-1:0] mem [MAX_WIDTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic             in_accept;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col_q;
    mem_wdata = {rd_q[3*G-1:2*G], in_mag_q, in_gx_q, in_gy_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_LOAD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_q <= mem[col_q];
    end
  end

  // Frame geometry with the used range of the size registers.
  logic [12:0] wclamp, col_next;
  logic [CFG_W-1:0] hclamp, row_next;
  logic col_last, row_last, eval_ok;

  always_comb begin
    wclamp = {2'b00, width_q};
    if (wclamp < 13'd3) begin
      wclamp = 13'd3;
    end else if (wclamp > 13'(MAX_WIDTH)) begin
      wclamp = 13'(MAX_WIDTH);
    end
    hclamp = height_q;
    if (hclamp < 11'd3) begin
      hclamp = 11'd3;
    end else if (hclamp > HEIGHT_LIMIT) begin
      hclamp = HEIGHT_LIMIT;
    end
    col_next = 13'(col_q) + 13'd1;
    row_next = 11'(row_q) + 11'd1;
    col_last = (col_next >= wclamp);
    row_last = (row_next >= hclamp);
    eval_ok  = (col_q >= AW'(2)) && (row_q >= 10'd2);
  end

  // Centre gradients as magnitudes for the pixel now held in the window.
  logic signed [G:0] cgx_ext, cgy_ext;
  logic [G:0]        cax, cay;

  always_comb begin
    cgx_ext = $signed({cgx_q[G-1], cgx_q});
    cgy_ext = $signed({cgy_q[G-1], cgy_q});
    cax     = cgx_ext[G] ? (G+1)'(-cgx_ext) : (G+1)'(cgx_ext);
    cay     = cgy_ext[G] ? (G+1)'(-cgy_ext) : (G+1)'(cgy_ext);
  end

  // Shared multiplier for the three squares of the octant test.
  logic [G:0]     mul_op;
  logic [2*G+1:0] mul_p;

  always_comb begin
    case (state_q)
      S_MUL0:  mul_op = ax_q + ay_q;
      S_MUL1:  mul_op = ay_q;
      default: mul_op = (ax_q > ay_q) ? (ax_q - ay_q) : (ay_q - ax_q);
    endcase
    mul_p = mul_op * mul_op;
  end

  logic [G-1:0] m_c;
  logic         axis_rej;
  assign m_c = win_q[4];

  always_comb begin
    if (ax_q > ay_q) begin
      axis_rej = (m_c <= win_q[5]) || (m_c < win_q[3]);
    end else begin
      axis_rej = (m_c <= win_q[1]) || (m_c < win_q[7]);
    end
  end

  // Octant choice, diagonal test and parabola terms.
  logic [2*G+2:0] two_aa;
  logic           cond_h, cond_v, same_sign, oct_rej;
  logic [G-1:0]   p_sel, q_sel;
  dir_e           dir_sel;
  logic signed [G+2:0] curv;

  always_comb begin
    two_aa    = {aa_q, 1'b0};
    cond_h    = (ax_q == '0 && ay_q == '0) || ({1'b0, ss_q} < two_aa);
    cond_v    = (ax_q > ay_q) && ({1'b0, dd_q} > two_aa);
    same_sign = (egx_q > 0) == (egy_q > 0);
    oct_rej   = 1'b0;
    if (cond_h) begin
      p_sel   = win_q[1];
      q_sel   = win_q[7];
      dir_sel = DIR_V;
    end else if (cond_v) begin
      p_sel   = win_q[3];
      q_sel   = win_q[5];
      dir_sel = DIR_H;
    end else if (same_sign) begin
      oct_rej = (m_c <= win_q[2]) || (m_c < win_q[6]);
      p_sel   = win_q[6];
      q_sel   = win_q[2];
      dir_sel = DIR_L;
    end else begin
      oct_rej = (m_c <= win_q[0]) || (m_c < win_q[8]);
      p_sel   = win_q[8];
      q_sel   = win_q[0];
      dir_sel = DIR_R;
    end
    curv = $signed({3'b000, p_sel}) + $signed({3'b000, q_sel})
         - $signed({2'b00, m_c, 1'b0});
  end

  // Offset checks and divider setup.
  logic signed [G+3:0] num2;
  logic                chk_rej;
  logic [G:0]          an;
  logic [G+3:0]        ad;

  always_comb begin
    num2 = $signed({{2{num_q[G+1]}}, num_q}) <<< 1;
    if (den_q == '0) begin
      chk_rej = 1'b1;
    end else if (den_q > 0) begin
      chk_rej = num2 > den_q;
    end else begin
      chk_rej = num2 < den_q;
    end
    an = num_q[G+1] ? (G+1)'(-num_q) : (G+1)'(num_q);
    ad = den_q[G+3] ? (G+4)'(-den_q) : (G+4)'(den_q);
  end

  logic [G+11:0] trial;
  logic          trial_ok;
  assign trial    = (G+12)'(dv_q) << step_q;
  assign trial_ok = {2'b00, rem_q} >= trial;

  // CORDIC for the normal angle, started as the divider starts.
  logic                      cordic_start, cordic_done;
  logic signed [ANGLE_W-1:0] angle;

  assign cordic_start = (state_q == S_CHECK) && !chk_rej;

  cnms_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .gx_i    (egx_q),
    .gy_i    (egy_q),
    .done_o  (cordic_done),
    .angle_o (angle)
  );

  // Subpixel position from the integer position and the signed offset.
  logic signed [8:0]  dq;
  logic signed [23:0] offx, offy, px, py;
  logic [POS_W-1:0]   pos_x, pos_y;
  logic [COUNT_W-1:0] cnt_inc;
  logic               out_free;

  always_comb begin
    dq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    case (dir_q)
      DIR_V:   begin offx = '0;       offy = 24'(dq);  end
      DIR_H:   begin offx = 24'(dq);  offy = '0;       end
      DIR_L:   begin offx = 24'(dq);  offy = -24'(dq); end
      default: begin offx = -24'(dq); offy = -24'(dq); end
    endcase
    px = $signed(24'({x_q, 8'h80})) + offx;
    py = $signed(24'({y_q, 8'h80})) + offy;
    if (px < 0) begin
      pos_x = '0;
    end else if (px > POS_MAX) begin
      pos_x = POS_W'(POS_MAX);
    end else begin
      pos_x = POS_W'(px);
    end
    if (py < 0) begin
      pos_y = '0;
    end else if (py > POS_MAX) begin
      pos_y = POS_W'(POS_MAX);
    end else begin
      pos_y = POS_W'(py);
    end
    cnt_inc  = (edge_q == COUNT_MAX) ? edge_q : edge_q + COUNT_W'(1);
    out_free = !out_valid_q || m_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      width_q     <= RESET_FRAME_WIDTH;
      height_q    <= RESET_FRAME_HEIGHT;
      col_q       <= '0;
      row_q       <= '0;
      edge_q      <= '0;
      in_gx_q     <= '0;
      in_gy_q     <= '0;
      in_mag_q    <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      cgx_q       <= '0;
      cgy_q       <= '0;
      egx_q       <= '0;
      egy_q       <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      frame_end_q <= 1'b0;
      ss_q        <= '0;
      aa_q        <= '0;
      dd_q        <= '0;
      dir_q       <= DIR_V;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      dv_q        <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default:          width_q  <= width_q;
        endcase
      end

      // In the emit state the edge register is reloaded below instead.
      if (out_valid_q && m_axis_tready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_WIDTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_accept) begin
            in_gx_q  <= s_axis_tdata[G-1:0];
            in_gy_q  <= s_axis_tdata[2*G-1:G];
            in_mag_q <= s_axis_tdata[3*G-1:2*G];
            state_q  <= S_LOAD;
          end
        end

        S_LOAD: begin
          // Shift the window and bring in the new column.
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= rd_q[4*G-1:3*G];
          win_q[3] <= win_q[4];
          win_q[4] <= win_q[5];
          win_q[5] <= rd_q[3*G-1:2*G];
          win_q[6] <= win_q[7];
          win_q[7] <= win_q[8];
          win_q[8] <= in_mag_q;
          // The window centre pairs with the gradients read one pixel ago.
          egx_q <= $signed(cgx_q);
          egy_q <= $signed(cgy_q);
          ax_q  <= cax;
          ay_q  <= cay;
          cgx_q <= rd_q[2*G-1:G];
          cgy_q <= rd_q[G-1:0];
          x_q   <= col_q - AW'(1);
          y_q   <= row_q - 10'd1;
          frame_end_q <= col_last && row_last;
          if (col_last) begin
            col_q <= '0;
            row_q <= row_last ? 10'd0 : row_q + 10'd1;
          end else begin
            col_q <= col_q + AW'(1);
          end
          if (eval_ok) begin
            state_q <= S_AXIS;
          end else begin
            if (col_last && row_last) begin
              edge_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end

        S_AXIS: begin
          if (axis_rej) begin
            if (frame_end_q) begin
              edge_q <= '0;
            end
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL0;
          end
        end

        S_MUL0: begin
          ss_q    <= mul_p;
          state_q <= S_MUL1;
        end

        S_MUL1: begin
          aa_q    <= mul_p;
          state_q <= S_MUL2;
        end

        S_MUL2: begin
          dd_q    <= mul_p;
          state_q <= S_OCT;
        end

        S_OCT: begin
          dir_q <= dir_sel;
          num_q <= $signed({2'b00, p_sel}) - $signed({2'b00, q_sel});
          den_q <= $signed({curv[G+2], curv}) <<< 1;
          if (oct_rej) begin
            if (frame_end_q) begin
              edge_q <= '0;
            end
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (chk_rej) begin
            if (frame_end_q) begin
              edge_q <= '0;
            end
            state_q <= S_IDLE;
          end else begin
            // Rounded quotient: (2 * |num| * 256 + |den|) / (2 * |den|).
            rem_q   <= {(G+1)'(an), 9'h000} + (G+10)'(ad);
            dv_q    <= {ad[G+2:0], 1'b0};
            neg_q   <= num_q[G+1] != den_q[G+3];
            quo_q   <= '0;
            step_q  <= 3'd7;
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          if (trial_ok) begin
            rem_q         <= (G+10)'({2'b00, rem_q} - trial);
            quo_q[step_q] <= 1'b1;
          end
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) begin
            state_q <= S_WAIT;
          end
        end

        S_WAIT: begin
          if (cordic_done) begin
            state_q <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {1'b0, cnt_inc, angle, m_c, pos_y, pos_x, y_q, 10'(x_q)};
            edge_q      <= frame_end_q ? '0 : cnt_inc;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== dv/cnms_edge_checker.sv =====
// Edge stream checker: predicts every edge transaction from the pixel stream and compares it.
`timescale 1ns / 1ps

module cnms_edge_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cnms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cnms_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [cnms_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [cnms_pkg::OUT_W-1:0]     m_axis_tdata,
  output int                             error_count_o,
  output int                             pending_o
);

  localparam int unsigned LINE_DEPTH = 1024;

  typedef struct {
    logic [9:0]         column;
    logic [9:0]         row;
    logic [18:0]        pos_x;
    logic [18:0]        pos_y;
    logic [15:0]        strength;
    logic signed [15:0] normal_angle;
    logic [20:0]        edge_count;
  } edge_t;

  edge_t       edge_q[$];
  int          errors;
  int unsigned fw, fh;
  int unsigned mag_up1[LINE_DEPTH];
  int unsigned mag_up2[LINE_DEPTH];
  int          gx_up[LINE_DEPTH];
  int          gy_up[LINE_DEPTH];
  int unsigned win[9];
  int          ctr_gx, ctr_gy;
  int unsigned col_cnt, row_cnt, edge_cnt;

  assign error_count_o = errors;
  assign pending_o     = edge_q.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint labs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Angle of (gx, -gy) in Q8.7 degrees from a 16-step CORDIC on values scaled by 256.
  function automatic longint cordic_angle(input longint gx, input longint gy);
    longint x, y, z, t, xs, ys, r;
    z = 0;
    if (gx == 0 && gy == 0) return 0;
    if (gy == 0 && gx < 0) return -23040;
    x = gx * 256;
    y = -gy * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 32768;
      end else begin
        x = -y; y = t; z = -90 * 32768;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(cnms_pkg::atan_lut(4'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(cnms_pkg::atan_lut(4'(i)));
      end
    end
    r = (z + 128) >>> 8;
    if (r > 23040) r = 23040;
    if (r < -23040) r = -23040;
    return r;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v < 0) return 0;
    if (v > 524287) return 524287;
    return v;
  endfunction

  // Suppression, octant choice and subpixel fit for the current window centre.
  function automatic bit judge_center(input int unsigned x, input int unsigned y,
                                      output edge_t e);
    longint m, gx, gy, ax, ay, s, d, p, q, num, den, an, ad, dq;
    int sx, sy;
    m  = win[4];
    gx = ctr_gx;
    gy = ctr_gy;
    ax = labs(gx);
    ay = labs(gy);
    e  = '{default: '0};
    if (ax > ay) begin
      if (m <= win[5] || m < win[3]) return 0;
    end else begin
      if (m <= win[1] || m < win[7]) return 0;
    end
    s = ax + ay;
    d = ax - ay;
    if ((ax == 0 && ay == 0) || s * s < 2 * ay * ay) begin
      p = win[1]; q = win[7]; sx = 0; sy = 1;
    end else if (ax > ay && d * d > 2 * ay * ay) begin
      p = win[3]; q = win[5]; sx = 1; sy = 0;
    end else if ((gx > 0) == (gy > 0)) begin
      if (m <= win[2] || m < win[6]) return 0;
      p = win[6]; q = win[2]; sx = 1; sy = -1;
    end else begin
      if (m <= win[0] || m < win[8]) return 0;
      p = win[8]; q = win[0]; sx = -1; sy = -1;
    end
    num = p - q;
    den = 2 * (p + q - 2 * m);
    if (den == 0) return 0;
    if (den > 0 ? (2 * num > den) : (2 * num < den)) return 0;
    an = labs(num) * 256;
    ad = labs(den);
    dq = (2 * an + ad) / (2 * ad);
    if ((num < 0) != (den < 0)) dq = -dq;
    if (edge_cnt < 2097151) edge_cnt++;
    e.column       = 10'(x);
    e.row          = 10'(y);
    e.pos_x        = 19'(clamp_pos(longint'(x) * 256 + 128 + sx * dq));
    e.pos_y        = 19'(clamp_pos(longint'(y) * 256 + 128 + sy * dq));
    e.strength     = 16'(m);
    e.normal_angle = 16'(cordic_angle(gx, gy));
    e.edge_count   = 21'(edge_cnt);
    return 1;
  endfunction

  task automatic take_pixel(input logic [cnms_pkg::IN_W-1:0] d);
    int unsigned w, h, c, r, mag, up1, up2;
    int gx, gy, ngx, ngy;
    edge_t e;
    w = fw; h = fh; c = col_cnt; r = row_cnt;
    up1 = 0; up2 = 0; ngx = 0; ngy = 0;
    gx  = int'($signed(d[15:0]));
    gy  = int'($signed(d[31:16]));
    mag = d[47:32];
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 3) h = 3;
    if (h > 1024) h = 1024;
    if (c < LINE_DEPTH) begin
      up2 = mag_up2[c]; up1 = mag_up1[c]; ngx = gx_up[c]; ngy = gy_up[c];
      mag_up2[c] = up1; mag_up1[c] = mag; gx_up[c] = gx; gy_up[c] = gy;
    end
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up2; win[5] = up1; win[8] = mag;
    if (c >= 2 && r >= 2 && judge_center(c - 1, r - 1, e)) edge_q.push_back(e);
    ctr_gx = ngx;
    ctr_gy = ngy;
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (r + 1 >= h) begin
        row_cnt = 0; edge_cnt = 0;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic check_edge(input logic [cnms_pkg::OUT_W-1:0] d);
    edge_t e;
    if (edge_q.size() == 0) begin
      report_mismatch("edge transactions beyond those expected", 1, 0);
      return;
    end
    e = edge_q.pop_front();
    if (d[9:0] != e.column) report_mismatch("column", d[9:0], e.column);
    if (d[19:10] != e.row) report_mismatch("row", d[19:10], e.row);
    if (d[38:20] != e.pos_x) report_mismatch("pos_x", d[38:20], e.pos_x);
    if (d[57:39] != e.pos_y) report_mismatch("pos_y", d[57:39], e.pos_y);
    if (d[73:58] != e.strength) report_mismatch("strength", d[73:58], e.strength);
    if ($signed(d[89:74]) != e.normal_angle)
      report_mismatch("normal_angle", $signed(d[89:74]), e.normal_angle);
    if (d[110:90] != e.edge_count) report_mismatch("edge_count", d[110:90], e.edge_count);
    if (d[111] != 1'b0) report_mismatch("pad bit", d[111], 0);
  endtask

  initial errors = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fw = cnms_pkg::RESET_FRAME_WIDTH;
      fh = cnms_pkg::RESET_FRAME_HEIGHT;
      foreach (mag_up1[i]) begin
        mag_up1[i] = 0; mag_up2[i] = 0; gx_up[i] = 0; gy_up[i] = 0;
      end
      foreach (win[i]) win[i] = 0;
      ctr_gx = 0; ctr_gy = 0; col_cnt = 0; row_cnt = 0; edge_cnt = 0;
      edge_q.delete();
    end else begin
      // An edge leaving now belongs to an earlier pixel, so check it first.
      if (m_axis_tvalid && m_axis_tready) check_edge(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
      if (cfg_we_i) begin
        if (cfg_index_i == cnms_pkg::REG_FRAME_WIDTH) fw = cfg_data_i;
        else if (cfg_index_i == cnms_pkg::REG_FRAME_HEIGHT) fh = cfg_data_i;
      end
    end
  end

endmodule

// ===== dv/tb_canny_nms_subpixel_top.sv =====
// Testbench top: pixel stimulus, edge stream back-pressure and the final verdict.
`timescale 1ns / 1ps

// The top drives pixel frames into the block and random back-pressure on the
// edge stream, while the checker beside the block predicts and compares every
// edge transaction. The run begins with a short directed frame that holds the
// gradient and magnitude extremes, the zero gradient vector and a purely
// negative horizontal gradient. Random phases follow, each with its own frame
// size; frame registers change only after every expected edge has arrived
// and the block has had time to finish any pixel still in flight. The frame
// size extremes, including out-of-range values that the block clamps, get
// phases of their own. Idle bursts on both sides stop in the final phases.
module tb_canny_nms_subpixel_top;

  localparam int unsigned TARGET_ITEMS = 1250;
  localparam int unsigned SETTLE_CYCLES = 40;   // longer than the pixel time of an edge
  localparam longint CYCLE_LIMIT = 2000000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cnms_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [cnms_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [cnms_pkg::IN_W-1:0]      s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [cnms_pkg::OUT_W-1:0]     m_axis_tdata;

  int     error_count;
  int     pending_edges;
  bit     idling_on;
  int     sink_stall;
  int     items_sent;
  longint cycle_count;

  canny_nms_subpixel_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cnms_edge_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_edges)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Watchdog over the whole run, including the line clearing pass after reset.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Edge stream back-pressure: random stall bursts while idling is on.
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall    <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      sink_stall    <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one pixel transaction. The caller sits just after a falling edge,
  // and the task returns just after the falling edge that follows acceptance,
  // so tvalid stays high between back-to-back pixels.
  task automatic send_pixel(input logic signed [15:0] gx, input logic signed [15:0] gy,
                            input logic [15:0] mag);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mag, gy, gx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Drops tvalid, waits for every predicted edge and for any pixel still in flight.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_edges != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [cnms_pkg::CFG_W-1:0] w,
                           input logic [cnms_pkg::CFG_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= cnms_pkg::REG_FRAME_WIDTH;
    cfg_data_i  <= w;
    @(negedge clk_i);
    cfg_index_i <= cnms_pkg::REG_FRAME_HEIGHT;
    cfg_data_i  <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_grad();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($urandom);
    if (sel < 8) return 16'($urandom_range(0, 6) - 3);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly moderate magnitudes so that local maxima and ties are common.
  function automatic logic [15:0] rand_mag();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom_range(0, 255));
    if (sel < 8) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_random_pixels(input int n);
    logic signed [15:0] gx, gy;
    for (int i = 0; i < n; i++) begin
      gx = rand_grad();
      // Equal magnitudes sit on the boundary between octants.
      gy = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? gx : -gx) : rand_grad();
      send_pixel(gx, gy, rand_mag());
    end
  endtask

  initial begin
    logic [15:0] mag;
    logic signed [15:0] gx, gy;
    int w, h, n;
    bit extremes_done;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = cnms_pkg::REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sink_stall    = 0;
    idling_on     = 1'b1;
    items_sent    = 0;
    cycle_count   = 0;
    extremes_done = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frame, 3 wide and 8 high: strong peaks in the middle column of
    // odd rows, each with a special gradient; even rows lie between peaks.
    set_frame(11'd3, 11'd8);
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 3; c++) begin
        mag = (c == 1 && r % 2 == 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
        gx  = 16'sh7FFF;
        gy  = 16'sh0100;
        if (c == 1) begin
          case (r)
            1: begin gx = 16'sh0000; gy = 16'sh0000; end    // zero gradient vector
            3: begin gx = 16'sh8000; gy = 16'sh0000; end    // negative horizontal only
            5: begin gx = 16'sh7FFF; gy = 16'sh8000; end    // extreme diagonal
            7: begin gx = 16'shFFFF; gy = 16'shFFFF; end
            default: begin gx = 16'sh8000; gy = 16'sh7FFF; end
          endcase
        end
        send_pixel(gx, gy, mag);
      end
    end
    drain_block();

    // Random phases with small frames; some phases end partway through a frame.
    while (items_sent < TARGET_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h) : w * h * $urandom_range(1, 2);
      set_frame(11'(w), 11'(h));
      send_random_pixels(n);
      drain_block();
      if (!extremes_done && items_sent > 700) begin
        // Frame size extremes, then values outside the range that get clamped.
        extremes_done = 1'b1;
        set_frame(11'd1024, 11'd3);
        send_random_pixels(200);
        drain_block();
        set_frame(11'd3, 11'd1024);
        send_random_pixels(150);
        drain_block();
        set_frame(11'd0, 11'h7FF);
        send_random_pixels(60);
        drain_block();
      end
      if (items_sent > TARGET_ITEMS * 9 / 10) idling_on = 1'b0;
    end

    // Final stretch with no idling on either side.
    idling_on = 1'b0;
    set_frame(11'd5, 11'd4);
    send_random_pixels(40);
    drain_block();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
